@@ rtl/core/lcdt_pkg.sv @@
// Shared types, codes and constants of the two-row character display terminal.
package lcdt_pkg;

    localparam int LINE_WIDTH = 16;

    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_NUL = 8'd0;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_MOVE  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRAP,
        ST_MOVE0,
        ST_REPLAY
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic emit;        // load a new display command into the output register
        cmd_t op;          // display command to load
        logic from_store;  // write character comes from the line store read port
        logic row_cur;     // move target is the current row
        logic row_val;     // move target when row_cur is low
        logic last;        // final command of this request
        logic take_char;   // advance column; on row 1 also store and count the character
        logic end_cr;      // finish a carriage return: row 1, column 0, store empty
        logic idx_clr;     // restart the replay index
        logic idx_inc;     // step the replay index
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_lf;
        logic is_cr;
        logic wrap;        // the next ordinary character fills the row
        logic more;        // another stored character is to be replayed
        logic slot_free;   // the output register can take a command this cycle
    } dp_status_t;

endpackage

@@ rtl/core/lcdt_if.sv @@
// Valid/ready channel interfaces for received characters and display commands.
interface lcdt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface lcdt_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_out;
    logic       target_row;
    logic       last;

    modport source (output valid, output command, output char_out, output target_row,
                    output last, input ready);
    modport sink   (input valid, input command, input char_out, input target_row,
                    input last, output ready);
endinterface

@@ rtl/core/lcdt_ctrl.sv @@
// Sequencing controller: decides which display command goes out in each cycle.
module lcdt_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lcdt_pkg::dp_status_t status,
    output lcdt_pkg::dp_cmd_t    cmd
);

    lcdt_pkg::state_t state_reg;
    lcdt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcdt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.op         = lcdt_pkg::CMD_WRITE;
        case (state_reg)
            lcdt_pkg::ST_IDLE:
            begin
                in_ready = status.slot_free;
                if (in_valid && status.slot_free)
                begin
                    if (status.is_lf)
                    begin
                        state_next = lcdt_pkg::ST_IDLE;
                    end
                    else if (status.is_cr)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.op      = lcdt_pkg::CMD_CLEAR;
                        cmd.idx_clr = 1'b1;
                        state_next  = lcdt_pkg::ST_MOVE0;
                    end
                    else
                    begin
                        cmd.emit      = 1'b1;
                        cmd.op        = lcdt_pkg::CMD_WRITE;
                        cmd.last      = !status.wrap;
                        cmd.take_char = 1'b1;
                        state_next    = status.wrap ? lcdt_pkg::ST_WRAP : lcdt_pkg::ST_IDLE;
                    end
                end
            end
            lcdt_pkg::ST_WRAP:
            begin
                if (status.slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.op      = lcdt_pkg::CMD_MOVE;
                    cmd.row_cur = 1'b1;
                    cmd.last    = 1'b1;
                    state_next  = lcdt_pkg::ST_IDLE;
                end
            end
            lcdt_pkg::ST_MOVE0:
            begin
                if (status.slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.op      = lcdt_pkg::CMD_MOVE;
                    cmd.row_val = 1'b0;
                    state_next  = lcdt_pkg::ST_REPLAY;
                end
            end
            lcdt_pkg::ST_REPLAY:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.more)
                    begin
                        cmd.op         = lcdt_pkg::CMD_WRITE;
                        cmd.from_store = 1'b1;
                        cmd.idx_inc    = 1'b1;
                    end
                    else
                    begin
                        cmd.op      = lcdt_pkg::CMD_MOVE;
                        cmd.row_val = 1'b1;
                        cmd.last    = 1'b1;
                        cmd.end_cr  = 1'b1;
                        state_next  = lcdt_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lcdt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/lcdt_dp.sv @@
// Datapath: cursor position, row-1 line store, replay index and output register.
module lcdt_dp
#(
    parameter int LINE_WIDTH = lcdt_pkg::LINE_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           char_in,
    input  lcdt_pkg::dp_cmd_t    cmd,
    output lcdt_pkg::dp_status_t status,
    lcdt_cmd_if.source           tx
);

    localparam int COL_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
    localparam int CNT_W = $clog2(LINE_WIDTH + 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_WIDTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_WIDTH);

    logic             row_reg,  row_next;
    logic [COL_W-1:0] col_reg,  col_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [CNT_W-1:0] idx_reg,  idx_next;
    logic             out_valid_reg, out_valid_next;

    logic [1:0]       command_reg;
    logic [7:0]       char_out_reg;
    logic             target_row_reg;
    logic             last_reg;

    logic [7:0]       line_mem [LINE_WIDTH];
    logic [7:0]       rd_data_reg;
    logic [COL_W-1:0] rd_addr;

    logic             wrap;
    logic             slot_free;

    assign wrap      = (col_reg == COL_LAST);
    assign slot_free = !out_valid_reg || tx.ready;

    always_comb
    begin
        status.is_lf     = (char_in == lcdt_pkg::CH_LF);
        status.is_cr     = (char_in == lcdt_pkg::CH_CR);
        status.wrap      = wrap;
        status.more      = (idx_reg < cnt_reg) && (rd_data_reg != lcdt_pkg::CH_NUL);
        status.slot_free = slot_free;
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.take_char)
        begin
            if (row_reg && (cnt_reg < CNT_FULL))
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (wrap)
            begin
                col_next = '0;
                row_next = !row_reg;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        if (cmd.end_cr)
        begin
            row_next = 1'b1;
            col_next = '0;
            cnt_next = '0;
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !tx.ready;
        end
    end

    // The read address follows the index's next value, so the registered read
    // data belongs to the current index whenever that index is below LINE_WIDTH.
    assign rd_addr = (idx_next < CNT_FULL) ? idx_next[COL_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= 1'b0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Entries below the stored count have always been written since the last
    // reset or carriage return, so the store needs no clearing.
    always_ff @(posedge clk)
    begin
        if (cmd.take_char && row_reg)
        begin
            line_mem[col_reg] <= char_in;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            command_reg <= cmd.op;
            last_reg    <= cmd.last;
            if (cmd.op == lcdt_pkg::CMD_WRITE)
            begin
                char_out_reg <= cmd.from_store ? rd_data_reg : char_in;
            end
            else
            begin
                char_out_reg <= lcdt_pkg::CH_NUL;
            end
            if (cmd.op == lcdt_pkg::CMD_MOVE)
            begin
                target_row_reg <= cmd.row_cur ? row_reg : cmd.row_val;
            end
            else
            begin
                target_row_reg <= 1'b0;
            end
        end
    end

    assign tx.valid      = out_valid_reg;
    assign tx.command    = command_reg;
    assign tx.char_out   = char_out_reg;
    assign tx.target_row = target_row_reg;
    assign tx.last       = last_reg;

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_LAST)
        else $error("column ran past the line width");

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("stored count ran past the line width");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> slot_free)
        else $error("command loaded while the output register was still occupied");

    a_cr_end_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.end_cr |=> (row_reg && (col_reg == '0) && (cnt_reg == '0)))
        else $error("carriage return did not leave row 1 with an empty store");

endmodule

@@ rtl/core/two_row_char_lcd_terminal_top.sv @@
// Top level of the two-row character display terminal.
// Each received character request becomes a short run of display command requests.
// A line feed is taken and produces nothing. Any other character except carriage
// return produces one write command. When that write fills the row, it is
// followed by a move to the start of the other row. While the cursor is on row 1
// the character is also kept in a line store of LINE_WIDTH bytes. A carriage
// return produces a clear, a move to row 0, one write per stored row-1 character
// (up to the stored count or the first zero byte), and a move to row 1. The
// store is then empty and the cursor sits at the start of row 1. The last flag
// marks the final command of every request. One command leaves per cycle while
// the sink is ready. The controller sequences one request at a time. The next
// character can be taken from the cycle after the last command of the previous
// one is loaded into the output register, as soon as that register is empty or
// hands its command to the sink in the same cycle. The store is a small memory
// with a registered read port that the replay steps through one entry per cycle
// while the output register has room; it needs no clearing pass after reset.
module two_row_char_lcd_terminal_top
#(
    parameter int LINE_WIDTH = lcdt_pkg::LINE_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    lcdt_char_if.sink   rx,
    lcdt_cmd_if.source  tx
);

    lcdt_pkg::dp_cmd_t    cmd;
    lcdt_pkg::dp_status_t status;
    logic                 in_ready;

    // The controller owns the request handshake on the character side.
    assign rx.ready = in_ready;

    lcdt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the cursor, the line store and the output register.
    lcdt_dp
    #(
        .LINE_WIDTH (LINE_WIDTH)
    )
    u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (rx.char_in),
        .cmd     (cmd),
        .status  (status),
        .tx      (tx)
    );

endmodule

@@ tb/lcdt_display_checker.sv @@
`timescale 1ns / 100ps
// Watches both channels of the display terminal, predicts the display commands and compares them.
module lcdt_display_checker
#(
    parameter int LINE_WIDTH = lcdt_pkg::LINE_WIDTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic       rx_ready,
    input  logic [7:0] rx_char,
    input  logic       tx_valid,
    input  logic       tx_ready,
    input  logic [1:0] tx_command,
    input  logic [7:0] tx_char,
    input  logic       tx_row,
    input  logic       tx_last,
    output int         mismatches,
    output int         awaited,
    output int         checked
);

    localparam int MAX_BURST = LINE_WIDTH + 3;

    typedef struct packed {
        lcdt_pkg::cmd_t command;
        logic [7:0]     char_out;
        logic           target_row;
        logic           last;
    } display_cmd_t;

    // Own copy of the terminal state.
    logic       cursor_row;
    int         cursor_col;
    int         line_len;
    logic [7:0] line_chars [LINE_WIDTH];

    display_cmd_t awaited_display_cmds [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Works out the commands one received character causes and queues them.
    task automatic predict_display_commands(input logic [7:0] ch);
        display_cmd_t burst [MAX_BURST];
        int           n;
        logic         stop;
        n = 0;
        stop = 1'b0;
        if (ch == lcdt_pkg::CH_LF)
            return;
        if (ch == lcdt_pkg::CH_CR)
        begin
            burst[n] = '{lcdt_pkg::CMD_CLEAR, 8'd0, 1'b0, 1'b0};
            n = n + 1;
            burst[n] = '{lcdt_pkg::CMD_MOVE, 8'd0, 1'b0, 1'b0};
            n = n + 1;
            for (int i = 0; i < LINE_WIDTH; i++)
            begin
                if (i >= line_len || line_chars[i] == lcdt_pkg::CH_NUL)
                    stop = 1'b1;
                if (!stop)
                begin
                    burst[n] = '{lcdt_pkg::CMD_WRITE, line_chars[i], 1'b0, 1'b0};
                    n = n + 1;
                end
            end
            burst[n] = '{lcdt_pkg::CMD_MOVE, 8'd0, 1'b1, 1'b0};
            n = n + 1;
            for (int i = 0; i < LINE_WIDTH; i++)
                line_chars[i] = 8'd0;
            cursor_row = 1'b1;
            cursor_col = 0;
            line_len = 0;
        end
        else
        begin
            burst[n] = '{lcdt_pkg::CMD_WRITE, ch, 1'b0, 1'b0};
            n = n + 1;
            if (cursor_row)
            begin
                line_chars[cursor_col] = ch;
                if (line_len < LINE_WIDTH)
                    line_len = line_len + 1;
            end
            cursor_col = cursor_col + 1;
            if (cursor_col >= LINE_WIDTH)
            begin
                cursor_row = ~cursor_row;
                cursor_col = 0;
                burst[n] = '{lcdt_pkg::CMD_MOVE, 8'd0, cursor_row, 1'b0};
                n = n + 1;
            end
        end
        burst[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            awaited_display_cmds.push_back(burst[i]);
    endtask

    task automatic check_display_command();
        display_cmd_t want;
        if (awaited_display_cmds.size() == 0)
        begin
            report_mismatch("unexpected command", tx_command, -1);
            return;
        end
        want = awaited_display_cmds.pop_front();
        checked++;
        if (tx_command !== want.command)
            report_mismatch("command", tx_command, want.command);
        if (tx_char !== want.char_out)
            report_mismatch("char_out", tx_char, want.char_out);
        if (tx_row !== want.target_row)
            report_mismatch("target_row", tx_row, want.target_row);
        if (tx_last !== want.last)
            report_mismatch("last", tx_last, want.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row = 1'b0;
            cursor_col = 0;
            line_len = 0;
            for (int i = 0; i < LINE_WIDTH; i++)
                line_chars[i] = 8'd0;
            awaited_display_cmds.delete();
            mismatches = 0;
            checked = 0;
            awaited = 0;
        end
        else
        begin
            if (rx_valid && rx_ready)
                predict_display_commands(rx_char);
            if (tx_valid && tx_ready)
                check_display_command();
            awaited = awaited_display_cmds.size();
        end
    end

endmodule

@@ tb/two_row_char_lcd_terminal_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top of the display terminal: character stimulus, command sink and verdict.
module two_row_char_lcd_terminal_top_tb;

    // A generous bound on the run, even with every request stalled at both ends.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 96;

    logic clk = 1'b0;
    logic rst_n;

    lcdt_char_if rx_ch ();
    lcdt_cmd_if  tx_ch ();

    int mismatches;
    int awaited;
    int checked;
    int cycles = 0;

    // When set, neither side inserts idle cycles, so requests go back to back.
    logic no_gaps;

    int sent_chars;
    int sent_returns;
    int sent_feeds;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    two_row_char_lcd_terminal_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    // The checker sits beside the block and only watches the two channels.
    lcdt_display_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_ch.valid),
        .rx_ready   (rx_ch.ready),
        .rx_char    (rx_ch.char_in),
        .tx_valid   (tx_ch.valid),
        .tx_ready   (tx_ch.ready),
        .tx_command (tx_ch.command),
        .tx_char    (tx_ch.char_out),
        .tx_row     (tx_ch.target_row),
        .tx_last    (tx_ch.last),
        .mismatches (mismatches),
        .awaited    (awaited),
        .checked    (checked)
    );

    // Watchdog: a hung handshake or a lost command ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d commands still awaited",
                     cycles, awaited);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 9);
    endfunction

    // Sends one character request. The idle gap comes first, with valid low;
    // valid is only lowered when there really is a gap, so back-to-back
    // requests keep it high. Inputs change at falling edges, and the handshake
    // is sampled at rising edges.
    task automatic send_char(input logic [7:0] ch);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.char_in <= ch;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent_chars++;
        if (ch == lcdt_pkg::CH_CR)
            sent_returns++;
        if (ch == lcdt_pkg::CH_LF)
            sent_feeds++;
    endtask

    // Picks a line character: mostly any byte, with line feeds and zero bytes
    // mixed in so that ignored input and early replay stops keep showing up.
    function automatic logic [7:0] draw_line_char();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return lcdt_pkg::CH_LF;
        if (pick == 1)
            return lcdt_pkg::CH_NUL;
        return 8'($urandom_range(0, 255));
    endfunction

    // Command sink: for every command it waits a drawn number of cycles with
    // ready low, then holds ready high until the command is taken.
    initial
    begin : command_sink
        int gap;
        tx_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            tx_ch.ready <= 1'b1;
            @(posedge clk);
            while (!tx_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int line_len;
        int random_sent;
        rst_n = 1'b0;
        rx_ch.valid = 1'b0;
        rx_ch.char_in = 8'd0;
        no_gaps = 1'b0;
        sent_chars = 0;
        sent_returns = 0;
        sent_feeds = 0;
        random_sent = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Carriage return straight after reset: the store is empty, so only
        // the clear and the two moves come out; the cursor ends on row 1.
        send_char(lcdt_pkg::CH_CR);
        // Extreme bytes typed on row 1 are kept in the store.
        send_char(8'hFF);
        send_char(8'h01);
        send_char(8'h80);
        send_char(8'h7F);
        // A line feed is taken and produces nothing.
        send_char(lcdt_pkg::CH_LF);
        // Replays the four stored bytes between the moves.
        send_char(lcdt_pkg::CH_CR);
        // A zero byte is written and stored, and the replay stops in front of it.
        send_char(8'h41);
        send_char(lcdt_pkg::CH_NUL);
        send_char(8'h42);
        send_char(lcdt_pkg::CH_CR);
        // Back-to-back requests with the sink always ready.
        no_gaps = 1'b1;
        send_char(8'h55);
        send_char(8'hAA);
        send_char(lcdt_pkg::CH_CR);
        no_gaps = 1'b0;

        // Random part: mostly lines of random content closed by a carriage
        // return. Long lines fill row 1, wrap to row 0 with the store
        // saturated, and may wrap back to row 1 to overwrite it from the start.
        while (random_sent < RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       line_len = $urandom_range(0, 4);
                1, 2:    line_len = $urandom_range(5, 18);
                default: line_len = $urandom_range(19, 40);
            endcase
            for (int i = 0; i < line_len && random_sent < RANDOM_ITEMS; i++)
            begin
                send_char(draw_line_char());
                random_sent++;
            end
            if ($urandom_range(0, 4) != 0)
            begin
                send_char(lcdt_pkg::CH_CR);
                random_sent++;
            end
        end
        rx_ch.valid <= 1'b0;
        no_gaps = 1'b0;

        // Drain: every predicted command must come out, then a short quiet
        // stretch catches anything extra. The watchdog bounds both waits.
        while (awaited != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d character requests (%0d carriage returns, %0d line feeds).",
                 sent_chars, sent_returns, sent_feeds);
        $display("Checked %0d display commands with random stalls on both channels.",
                 checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
